// ===== rtl/b64pe_pkg.sv =====
// ----------------------------------------------------------------------------
// b64pe_pkg
// Shared types and helpers for the percent-escaped base64 encoder.
// ----------------------------------------------------------------------------
package b64pe_pkg;

	localparam int unsigned SymsPerJob = 4;

	localparam logic [5:0] SextetPlus  = 6'd62;
	localparam logic [5:0] SextetSlash = 6'd63;

	localparam logic [7:0] ChrPercent = 8'h25;
	localparam logic [7:0] ChrTwo     = 8'h32;
	localparam logic [7:0] ChrThree   = 8'h33;
	localparam logic [7:0] ChrUpperB  = 8'h42;
	localparam logic [7:0] ChrUpperD  = 8'h44;
	localparam logic [7:0] ChrUpperF  = 8'h46;
	localparam logic [7:0] ChrUpperA  = 8'h41;
	localparam logic [7:0] ChrLowerA  = 8'h61;
	localparam logic [7:0] ChrZero    = 8'h30;

	// one output symbol: a sextet or an escaped '=' pad
	typedef struct packed {
		logic       pad;
		logic [5:0] sextet;
	} sym_t;

	// work for one input item, symbols used from index 0 to last_sym
	typedef struct packed {
		logic                       fin;
		logic [1:0]                 last_sym;
		sym_t [SymsPerJob-1:0]      syms;
	} job_t;

	// base64 letter for sextets below 62
	function automatic logic [7:0] b64_letter(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = ChrUpperA + {2'b00, v};
		end else if (v < 6'd52) begin
			r = ChrLowerA + {2'b00, v} - 8'd26;
		end else begin
			r = ChrZero + {2'b00, v} - 8'd52;
		end
		return r;
	endfunction

endpackage

// ===== rtl/b64pe_front.sv =====
// ----------------------------------------------------------------------------
// b64pe_front
// Takes input bytes, tracks the 3-byte group phase and splits each byte
// into the sextets and pads it produces.
// ----------------------------------------------------------------------------
module b64pe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	input  logic              q_full,
	output logic              push,
	output b64pe_pkg::job_t   push_job
);
	import b64pe_pkg::*;

	logic [1:0] phase_q;
	logic [3:0] left_q;
	logic [1:0] phase_d;
	logic [3:0] left_d;
	sym_t       pad_sym;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign pad_sym  = '{pad: 1'b1, sextet: 6'd0};

	always_comb begin
		push_job     = '0;
		push_job.fin = final_byte;
		phase_d      = 2'd0;
		left_d       = 4'd0;
		unique case (phase_q)
			2'd1: begin
				push_job.syms[0]  = '{pad: 1'b0, sextet: {left_q[1:0], data_byte[7:4]}};
				push_job.syms[1]  = '{pad: 1'b0, sextet: {data_byte[3:0], 2'b00}};
				push_job.syms[2]  = pad_sym;
				push_job.last_sym = final_byte ? 2'd2 : 2'd0;
				phase_d           = 2'd2;
				left_d            = data_byte[3:0];
			end
			2'd2: begin
				push_job.syms[0]  = '{pad: 1'b0, sextet: {left_q, data_byte[7:6]}};
				push_job.syms[1]  = '{pad: 1'b0, sextet: data_byte[5:0]};
				push_job.last_sym = 2'd1;
			end
			default: begin
				// phase 3 never arises and acts as phase 0
				push_job.syms[0]  = '{pad: 1'b0, sextet: data_byte[7:2]};
				push_job.syms[1]  = '{pad: 1'b0, sextet: {data_byte[1:0], 4'b0000}};
				push_job.syms[2]  = pad_sym;
				push_job.syms[3]  = pad_sym;
				push_job.last_sym = final_byte ? 2'd3 : 2'd0;
				phase_d           = 2'd1;
				left_d            = {2'b00, data_byte[1:0]};
			end
		endcase
		if (final_byte) begin
			phase_d = 2'd0;
			left_d  = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			left_q  <= 4'd0;
		end else if (push) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

// ===== rtl/b64pe_queue.sv =====
// ----------------------------------------------------------------------------
// b64pe_queue
// Small register queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64pe_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64pe_pkg::job_t   push_job,
	input  logic              pop,
	output b64pe_pkg::job_t   head_job,
	output logic              empty,
	output logic              full
);
	import b64pe_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t            slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign empty    = (count_q == CW'(0));
	assign full     = (count_q == CW'(DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/b64pe_back.sv =====
// ----------------------------------------------------------------------------
// b64pe_back
// Walks the symbols of the head job, one character per cycle while the output is not
// stalled, expanding '+', '/' and pads into percent escapes, into an output register.
// ----------------------------------------------------------------------------
module b64pe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64pe_pkg::job_t   head_job,
	input  logic              empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_char,
	output logic              run_end,
	output logic              message_end
);
	import b64pe_pkg::*;

	logic [1:0] sym_idx_q;
	logic [1:0] chr_idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_end_q;
	logic       message_end_q;

	sym_t       cur;
	logic       esc;
	logic       last_chr;
	logic       last_sym;
	logic       load_ok;
	logic       emit;
	logic [7:0] chr;

	assign cur      = head_job.syms[sym_idx_q];
	assign esc      = cur.pad || (cur.sextet == SextetPlus) || (cur.sextet == SextetSlash);
	assign last_chr = !esc || (chr_idx_q == 2'd2);
	assign last_sym = (sym_idx_q == head_job.last_sym);
	assign load_ok  = !out_valid_q || !out_stall;
	assign emit     = load_ok && !empty;
	assign pop      = emit && last_chr && last_sym;

	always_comb begin
		if (!esc) begin
			chr = b64_letter(cur.sextet);
		end else begin
			case (chr_idx_q)
				2'd0:    chr = ChrPercent;
				2'd1:    chr = cur.pad ? ChrThree : ChrTwo;
				default: chr = cur.pad ? ChrUpperD : (cur.sextet[0] ? ChrUpperF : ChrUpperB);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_idx_q   <= 2'd0;
			chr_idx_q   <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				if (last_chr) begin
					chr_idx_q <= 2'd0;
					sym_idx_q <= last_sym ? 2'd0 : sym_idx_q + 2'd1;
				end else begin
					chr_idx_q <= chr_idx_q + 2'd1;
				end
			end else if (load_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q    <= chr;
			run_end_q     <= last_chr && last_sym;
			message_end_q <= last_chr && last_sym && head_job.fin;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign run_end     = run_end_q;
	assign message_end = message_end_q;

endmodule

// ===== rtl/base64_percent_escaped_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_percent_escaped_encoder
// Streaming base64 encoder with '+', '/' and '=' written as percent escapes.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one message byte per item
// (data_byte) with final_byte set on the last byte of a message.
// Output channel: out_valid / out_stall carry one ASCII character per item
// (out_char); run_end marks the last character caused by an input byte and
// message_end the last character of the whole encoded message.
// Each byte yields one to four symbols (sextets or '=' pads); a symbol is one
// character, or three when it becomes %2B, %2F or %3D, so a byte gives 1 to
// 10 characters, about 1.3 on plain data. The back end sends one character
// per cycle while the receiver does not stall. With the queue empty, the
// first character of a byte passes through the queue and then the output
// register. A queue of QUEUE_DEPTH jobs lets bytes be taken while earlier
// ones are still being sent; in_stall rises only when it fills.
// Reset clears the group phase, the queue and the output valid bit. While the
// receiver stalls, the output character holds and the queue keeps filling.
// ----------------------------------------------------------------------------
module base64_percent_escaped_encoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_end,
	output logic       message_end
);
	import b64pe_pkg::*;

	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic q_empty;
	logic q_full;

	b64pe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	b64pe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	b64pe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.empty       (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_end     (run_end),
		.message_end (message_end)
	);

	// end of message is always also end of the byte's run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_end |-> run_end)
		else $error("message_end without run_end");

	// escaped characters never leave the block raw
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char != 8'h2b) && (out_char != 8'h2f) && (out_char != 8'h3d))
		else $error("raw '+', '/' or '=' on output");

	// a percent sign always starts an escape, never ends a run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_char == ChrPercent) |-> !run_end)
		else $error("escape cut short");

	// the back end never pops from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule
